>>> sv/d8fd_pkg.sv
// d8fd_pkg: widths, weights, codes and shared types of the d8 flow direction block
// no dependencies; used by d8fd_pick and d8_flow_direction
`default_nettype none

package d8fd_pkg;

  localparam int ELEV_BITS   = 16;
  localparam int MAX_COLS    = 2048;
  localparam int COL_BITS    = $clog2(MAX_COLS);
  localparam int ROW_BITS    = 16;
  localparam int CFG_COLS_W  = 12;
  localparam int DROP_BITS   = ELEV_BITS + 1;
  localparam int WCONST_BITS = 18;
  localparam int WEIGHT_BITS = ELEV_BITS + WCONST_BITS;
  localparam int CODE_BITS   = 4;
  localparam int NB_SLOTS    = 8;

  // orthogonal drop weighs d*141421, diagonal d*100000
  localparam logic [WEIGHT_BITS-1:0] W_ORTH = WEIGHT_BITS'(141421);
  localparam logic [WEIGHT_BITS-1:0] W_DIAG = WEIGHT_BITS'(100000);

  // slots hold codes 0,1,2,3,5,6,7,8; diagonal codes 0,2,6,8 sit in slots 0,2,5,7
  localparam logic [NB_SLOTS-1:0] DIAG_SLOTS = 8'b1010_0101;

  localparam logic [CODE_BITS-1:0] CODE_PIT = 4'd4;

  typedef enum logic {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_e;

  typedef logic signed [ELEV_BITS-1:0] elev_t;

  typedef struct packed {
    logic run_last;
    logic frame_last;
  } tag_t;

  typedef struct packed {
    logic [ELEV_BITS-1:0]                center;
    logic [NB_SLOTS-1:0][ELEV_BITS-1:0]  nb;
    logic [NB_SLOTS-1:0]                 ok;
    tag_t                                tag;
  } job_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] w;
    logic [CODE_BITS-1:0]   code;
  } cand_t;

  function automatic logic [CODE_BITS-1:0] slot_code(int s);
    return CODE_BITS'((s < 4) ? s : s + 1);
  endfunction

endpackage

`default_nettype wire

>>> sv/d8_flow_direction.sv
// d8_flow_direction: streaming d8 flow direction with line store memory and 3x3 window
// depends on d8fd_pkg and d8fd_pick
//
//   channel   dir  handshake               payload
//   s_*       in   s_tvalid / s_tready     s_tdata: elevation
//   m_*       out  m_tvalid / m_tready     m_tdata: flow_code, m_tlast: run_last,
//                                          m_tuser: frame_last
//   apb       in   psel/penable/pwrite     0x0 grid_rows, 0x4 grid_cols
//
// one item per cycle while m_tready is high; an item that gives two results (end of a row below the first, or past
// the first column of the last row), or four for the final item of a frame, holds the input until all are issued,
// as one window position is issued per cycle to the picker.
// the first result of an item is offered after the item stage, the window stage and the picker pipeline; the rest
// follow in order.
// the line store (one read and one write port) has no clearing pass after reset.
// m_tready low fills the picker pipeline, then s_tready drops.
`default_nettype none

module d8_flow_direction (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic signed [15:0] s_tdata,   // elevation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,          // flow_code[3:0], zero [7:4]
  output logic        m_tlast,
  output logic        m_tuser,          // frame_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int EB = d8fd_pkg::ELEV_BITS;

  // configuration
  logic [d8fd_pkg::ROW_BITS-1:0]   grid_rows_q;
  logic [d8fd_pkg::CFG_COLS_W-1:0] grid_cols_q;
  logic [d8fd_pkg::ROW_BITS-1:0]   lastr;
  logic [d8fd_pkg::CFG_COLS_W-1:0] cols_m1;
  logic [d8fd_pkg::COL_BITS-1:0]   lastc;
  logic [d8fd_pkg::ROW_BITS-1:0]   wr_rows;
  logic [d8fd_pkg::CFG_COLS_W-1:0] wr_cols;
  logic                            cfg_we;
  d8fd_pkg::reg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = d8fd_pkg::reg_idx_e'(paddr[2]);
  assign lastr   = grid_rows_q - 16'd1;
  assign cols_m1 = grid_cols_q - 12'd1;
  assign lastc   = cols_m1[d8fd_pkg::COL_BITS-1:0];

  always_comb begin
    wr_rows = pwdata[15:0];
    if (wr_rows < 16'd2) wr_rows = 16'd2;
    wr_cols = pwdata[11:0];
    if (wr_cols < 12'd2) begin
      wr_cols = 12'd2;
    end else if (wr_cols > 12'(d8fd_pkg::MAX_COLS)) begin
      wr_cols = 12'(d8fd_pkg::MAX_COLS);
    end
  end

  always_comb begin
    unique case (cfg_idx)
      d8fd_pkg::REG_GRID_ROWS: prdata = 32'(grid_rows_q);
      d8fd_pkg::REG_GRID_COLS: prdata = 32'(grid_cols_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= 16'd2;
      grid_cols_q <= 12'd2;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        d8fd_pkg::REG_GRID_ROWS: grid_rows_q <= wr_rows;
        d8fd_pkg::REG_GRID_COLS: grid_cols_q <= wr_cols;
        default: ;
      endcase
    end
  end

  // position counters
  logic [d8fd_pkg::ROW_BITS-1:0] row_count_q;
  logic [d8fd_pkg::COL_BITS-1:0] col_count_q;
  logic                          s_accept;
  logic [3:0]                    mask_new;

  assign s_accept = s_tvalid && s_tready;

  // results: (r-1,c-1), (r-1,C-1), (R-1,c-1), (R-1,C-1)
  always_comb begin
    mask_new[0] = (row_count_q != '0) && (col_count_q != '0);
    mask_new[1] = (row_count_q != '0) && (col_count_q == lastc);
    mask_new[2] = (row_count_q == lastr) && (col_count_q != '0);
    mask_new[3] = (row_count_q == lastr) && (col_count_q == lastc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      col_count_q <= '0;
    end else if (cfg_we) begin
      row_count_q <= '0;
      col_count_q <= '0;
    end else if (s_accept) begin
      if (col_count_q == lastc) begin
        col_count_q <= '0;
        row_count_q <= (row_count_q == lastr) ? '0 : row_count_q + 16'd1;
      end else begin
        col_count_q <= col_count_q + 11'd1;
      end
    end
  end

  // item stage
  logic                  s1_v_q;
  logic [EB-1:0]         s1_sample_q;
  logic [3:0]            s1_mask_q;
  logic                  s1_rge2_q, s1_cge2_q;
  logic                  s1_adv;

  // line store: [EB-1:0] row r-1, [2*EB-1:EB] row r-2
  logic [2*EB-1:0]               line_mem [d8fd_pkg::MAX_COLS];
  logic [2*EB-1:0]               rdata_q;
  logic                          wr_pend_q;
  logic [d8fd_pkg::COL_BITS-1:0] wr_addr_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) rdata_q <= line_mem[col_count_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) line_mem[wr_addr_q] <= {rdata_q[EB-1:0], s1_sample_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= s_accept;
      if (s_tready) s1_v_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_sample_q <= s_tdata;
      s1_mask_q   <= mask_new;
      s1_rge2_q   <= row_count_q >= 16'd2;
      s1_cge2_q   <= col_count_q >= 11'd2;
      wr_addr_q   <= col_count_q;
    end
  end

  // window stage: issues one window position per cycle while the picker is ready
  logic [EB-1:0]  win_q   [3][3];
  logic [EB-1:0]  win_ext [4][4];
  logic [EB-1:0]  nbhd    [3][3];
  logic           s2_v_q;
  logic [3:0]     s2_mask_q;
  logic           s2_rge2_q, s2_cge2_q;
  logic           job_ready, s2_issue, s2_single, s2_free;
  logic [1:0]     kind;
  logic           hi_r, hi_c, top_ok, bot_ok, left_ok, right_ok;
  logic [3:0]     lowest;
  logic [d8fd_pkg::NB_SLOTS-1:0]        ok_w;
  logic [d8fd_pkg::NB_SLOTS-1:0][EB-1:0] nb_w;
  d8fd_pkg::job_t job;

  assign lowest    = s2_mask_q & (~s2_mask_q + 4'd1);
  assign s2_single = (s2_mask_q & (s2_mask_q - 4'd1)) == 4'd0;
  assign s2_issue  = s2_v_q && job_ready;
  assign s2_free   = !s2_v_q || (s2_issue && s2_single);
  assign s1_adv    = s1_v_q && s2_free;
  assign s_tready  = !s1_v_q || s1_adv;

  always_comb begin
    priority if (s2_mask_q[0]) kind = 2'd0;
    else if (s2_mask_q[1])     kind = 2'd1;
    else if (s2_mask_q[2])     kind = 2'd2;
    else                       kind = 2'd3;
  end

  assign hi_r     = kind[1];
  assign hi_c     = kind[0];
  assign top_ok   = hi_r || s2_rge2_q;
  assign bot_ok   = !hi_r;
  assign left_ok  = hi_c || s2_cge2_q;
  assign right_ok = !hi_c;

  for (genvar a = 0; a < 4; a++) begin : g_ext_r
    for (genvar b = 0; b < 4; b++) begin : g_ext_c
      if (a < 3 && b < 3) begin : g_in
        assign win_ext[a][b] = win_q[a][b];
      end else begin : g_out
        assign win_ext[a][b] = '0;
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_nb_r
    for (genvar b = 0; b < 3; b++) begin : g_nb_c
      assign nbhd[a][b] = hi_r ? (hi_c ? win_ext[a+1][b+1] : win_ext[a+1][b])
                               : (hi_c ? win_ext[a][b+1]   : win_ext[a][b]);
    end
  end

  // code i: row offset (i mod 3)-1, column offset (i div 3)-1
  for (genvar s = 0; s < d8fd_pkg::NB_SLOTS; s++) begin : g_slot
    localparam int I = (s < 4) ? s : s + 1;
    localparam int A = I % 3;
    localparam int B = I / 3;
    assign nb_w[s] = nbhd[A][B];
    assign ok_w[s] = (A == 0 ? top_ok  : (A == 2 ? bot_ok   : 1'b1))
                   & (B == 0 ? left_ok : (B == 2 ? right_ok : 1'b1));
  end

  always_comb begin
    job.center         = nbhd[1][1];
    job.nb             = nb_w;
    job.ok             = ok_w;
    job.tag.run_last   = s2_single;
    job.tag.frame_last = (kind == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s1_adv) begin
      s2_v_q <= |s1_mask_q;
    end else if (s2_issue) begin
      s2_v_q <= !s2_single;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_mask_q <= s1_mask_q;
      s2_rge2_q <= s1_rge2_q;
      s2_cge2_q <= s1_cge2_q;
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rdata_q[2*EB-1:EB];
      win_q[1][2] <= rdata_q[EB-1:0];
      win_q[2][2] <= s1_sample_q;
    end else if (s2_issue) begin
      s2_mask_q <= s2_mask_q & ~lowest;
    end
  end

  logic [d8fd_pkg::CODE_BITS-1:0] flow_code;

  d8fd_pick u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (s2_v_q),
    .job_ready_o  (job_ready),
    .job_i        (job),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .flow_code_o  (flow_code),
    .run_last_o   (m_tlast),
    .frame_last_o (m_tuser)
  );

  assign m_tdata = {4'd0, flow_code};

  // no read of an entry in the same cycle as its write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_pend_q && s_accept) |-> (wr_addr_q != col_count_q))
    else $error("line store read collides with write-back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> $past(s_tvalid && s_tready))
    else $error("write-back without an accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_mask_q != 4'd0))
    else $error("window stage valid with no pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("frame end not marked as last of run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_count_q <= lastc)
    else $error("column counter beyond row end");

endmodule

`default_nettype wire

>>> sv/d8fd_pick.sv
// d8fd_pick: pipelined steepest-drop selection for one window position per item
// depends on d8fd_pkg
`default_nettype none

module d8fd_pick (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  d8fd_pkg::job_t     job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [d8fd_pkg::CODE_BITS-1:0] flow_code_o,
  output logic               run_last_o,
  output logic               frame_last_o
);

  function automatic d8fd_pkg::cand_t pick_max(d8fd_pkg::cand_t l, d8fd_pkg::cand_t r);
    return (r.w > l.w) ? r : l;
  endfunction

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [d8fd_pkg::ELEV_BITS-1:0]   mag1_d [d8fd_pkg::NB_SLOTS];
  logic [d8fd_pkg::ELEV_BITS-1:0]   mag1_q [d8fd_pkg::NB_SLOTS];
  logic [d8fd_pkg::WEIGHT_BITS-1:0] w2_q   [d8fd_pkg::NB_SLOTS];
  d8fd_pkg::cand_t                  c3_q   [4];
  d8fd_pkg::cand_t                  c4_q   [2];
  d8fd_pkg::cand_t                  best5;
  logic [d8fd_pkg::CODE_BITS-1:0]   code5_q;
  d8fd_pkg::tag_t                   tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign job_ready_o = rdy1;

  // drop against each neighbour, zero where excluded or not downhill
  always_comb begin
    logic signed [d8fd_pkg::DROP_BITS-1:0] diff;
    for (int s = 0; s < d8fd_pkg::NB_SLOTS; s++) begin
      diff = {job_i.center[d8fd_pkg::ELEV_BITS-1], job_i.center}
           - {job_i.nb[s][d8fd_pkg::ELEV_BITS-1], job_i.nb[s]};
      if (job_i.ok[s] && !diff[d8fd_pkg::DROP_BITS-1] && (diff != '0)) begin
        mag1_d[s] = diff[d8fd_pkg::ELEV_BITS-1:0];
      end else begin
        mag1_d[s] = '0;
      end
    end
  end

  assign best5 = pick_max(c4_q[0], c4_q[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= job_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      mag1_q <= mag1_d;
      tag1_q <= job_i.tag;
    end
    if (rdy2) begin
      for (int s = 0; s < d8fd_pkg::NB_SLOTS; s++) begin
        w2_q[s] <= d8fd_pkg::WEIGHT_BITS'(mag1_q[s])
                 * (d8fd_pkg::DIAG_SLOTS[s] ? d8fd_pkg::W_DIAG : d8fd_pkg::W_ORTH);
      end
      tag2_q <= tag1_q;
    end
    if (rdy3) begin
      for (int p = 0; p < 4; p++) begin
        c3_q[p] <= pick_max('{w: w2_q[2*p],   code: d8fd_pkg::slot_code(2*p)},
                            '{w: w2_q[2*p+1], code: d8fd_pkg::slot_code(2*p+1)});
      end
      tag3_q <= tag2_q;
    end
    if (rdy4) begin
      c4_q[0] <= pick_max(c3_q[0], c3_q[1]);
      c4_q[1] <= pick_max(c3_q[2], c3_q[3]);
      tag4_q  <= tag3_q;
    end
    if (rdy5) begin
      code5_q <= (best5.w == '0) ? d8fd_pkg::CODE_PIT : best5.code;
      tag5_q  <= tag4_q;
    end
  end

  assign out_valid_o  = v5_q;
  assign flow_code_o  = code5_q;
  assign run_last_o   = tag5_q.run_last;
  assign frame_last_o = tag5_q.frame_last;

endmodule

`default_nettype wire

>>> tb/tb_d8_flow_direction.sv
// tb_d8_flow_direction: streams elevation rasters through the d8 flow direction block
// and checks every flow code against an in-bench line store and window predictor
// depends on d8fd_pkg and d8_flow_direction
`timescale 1ns / 100ps

module tb_d8_flow_direction;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [d8fd_pkg::CODE_BITS-1:0] code;
    logic                           run_last;
    logic                           frame_last;
  } flow_cell_t;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic signed [15:0] s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;
  logic               m_tlast;
  logic               m_tuser;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [2:0]         paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  d8fd_pkg::elev_t elev_queue[$];
  flow_cell_t      flow_expect_q[$];

  d8fd_pkg::elev_t store_a [d8fd_pkg::MAX_COLS];
  d8fd_pkg::elev_t store_b [d8fd_pkg::MAX_COLS];
  d8fd_pkg::elev_t win [9];
  int    row_pos  = 0;
  int    col_pos  = 0;
  int    rows_cfg = 2;
  int    cols_cfg = 2;

  bit src_gaps_on = 1'b0;
  bit snk_gaps_on = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;
  int hold_left = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int err_count = 0;

  d8_flow_direction uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [d8fd_pkg::CODE_BITS-1:0] steepest_code(int wr, int wc,
                                                                  int gr, int gc);
    longint ctr, drop, wt, best;
    logic [d8fd_pkg::CODE_BITS-1:0] code;
    int dr, dc, nr, nc;
    ctr  = win[wr*3+wc];
    best = 0;
    code = d8fd_pkg::CODE_PIT;
    for (int i = 0; i < 9; i++) begin
      dr = (i % 3) - 1;
      dc = (i / 3) - 1;
      nr = wr + dr;
      nc = wc + dc;
      if (i != 4 && gr + dr >= 0 && gr + dr < rows_cfg && gc + dc >= 0 && gc + dc < cols_cfg
          && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2) begin
        drop = ctr - longint'(win[nr*3+nc]);
        wt = drop * ((dr != 0 && dc != 0) ? longint'(d8fd_pkg::W_DIAG)
                                          : longint'(d8fd_pkg::W_ORTH));
        if (wt > best) begin
          best = wt;
          code = d8fd_pkg::CODE_BITS'(i);
        end
      end
    end
    return code;
  endfunction

  function automatic void predict_flow(d8fd_pkg::elev_t sample);
    flow_cell_t made [4];
    int n, r, c;
    d8fd_pkg::elev_t above, above2;
    r = row_pos;
    c = col_pos;
    n = 0;
    above  = store_a[c];
    above2 = store_b[c];
    store_b[c] = above;
    store_a[c] = sample;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = above2;
    win[5] = above;
    win[8] = sample;
    if (r >= 1 && c >= 1) begin
      made[n] = '{steepest_code(1, 1, r - 1, c - 1), 1'b0, 1'b0};
      n++;
    end
    if (r >= 1 && c == cols_cfg - 1) begin
      made[n] = '{steepest_code(1, 2, r - 1, c), 1'b0, 1'b0};
      n++;
    end
    if (r == rows_cfg - 1 && c >= 1) begin
      made[n] = '{steepest_code(2, 1, r, c - 1), 1'b0, 1'b0};
      n++;
    end
    if (r == rows_cfg - 1 && c == cols_cfg - 1) begin
      made[n] = '{steepest_code(2, 2, r, c), 1'b0, 1'b1};
      n++;
    end
    for (int k = 0; k < n; k++) begin
      made[k].run_last = (k == n - 1);
      flow_expect_q.push_back(made[k]);
    end
    c++;
    if (c >= cols_cfg) begin
      c = 0;
      r++;
      if (r >= rows_cfg) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  function automatic void set_grid(d8fd_pkg::reg_idx_e idx, logic [31:0] value);
    case (idx)
      d8fd_pkg::REG_GRID_ROWS: rows_cfg = (value[15:0] < 2) ? 2 : int'(value[15:0]);
      d8fd_pkg::REG_GRID_COLS: begin
        if (value[11:0] < 2) cols_cfg = 2;
        else if (value[11:0] > d8fd_pkg::MAX_COLS) cols_cfg = d8fd_pkg::MAX_COLS;
        else cols_cfg = int'(value[11:0]);
      end
      default: ;
    endcase
    row_pos = 0;
    col_pos = 0;
    foreach (win[i]) win[i] = '0;
  endfunction

  function automatic d8fd_pkg::elev_t rand_elev();
    case ($urandom_range(0, 3))
      0: return d8fd_pkg::elev_t'($urandom);
      1: return d8fd_pkg::elev_t'($urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return d8fd_pkg::elev_t'($urandom_range(0, 40)) - 16'sd20;
    endcase
  endfunction

  // item source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) predict_flow(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (src_gaps_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 11);
          s_tvalid <= 1'b0;
        end else if (elev_queue.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= elev_queue.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk_i or negedge rst_ni) begin
    flow_cell_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (results_seen == 40) hold_left = HOLD_CYCLES;
        if (flow_expect_q.size() == 0) begin
          $error("unexpected item: flow_code %0d run_last %0b frame_last %0b",
                 m_tdata, m_tlast, m_tuser);
          err_count++;
        end else begin
          want = flow_expect_q.pop_front();
          if (m_tdata !== {4'b0, want.code}) begin
            $error("flow_code expected %0d got %0d", want.code, m_tdata);
            err_count++;
          end
          if (m_tlast !== want.run_last) begin
            $error("run_last expected %0b got %0b", want.run_last, m_tlast);
            err_count++;
          end
          if (m_tuser !== want.frame_last) begin
            $error("frame_last expected %0b got %0b", want.frame_last, m_tuser);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (snk_gaps_on && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 11);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (elev_queue.size() != 0 || s_tvalid || flow_expect_q.size() != 0);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic apb_write(d8fd_pkg::reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_grid(idx, value);
  endtask

  task automatic run_raster(logic [31:0] rows_w, logic [31:0] cols_w, int count);
    wait_idle();
    apb_write(d8fd_pkg::REG_GRID_ROWS, rows_w);
    apb_write(d8fd_pkg::REG_GRID_COLS, cols_w);
    @(negedge clk_i);
    repeat (count) elev_queue.push_back(rand_elev());
  endtask

  initial begin
    d8fd_pkg::elev_t frame_a [8] = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1,
                                     16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    d8fd_pkg::elev_t frame_b [18] = '{16'sd0, 16'sd90, 16'sd0, 16'sd90, 16'sd100, 16'sd90,
                                      16'sd0, 16'sd90, 16'sd0, 16'sd5, 16'sd5, 16'sd5,
                                      16'sd5, 16'sd9, 16'sd5, 16'sd5, 16'sd5, 16'sd3};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    src_gaps_on = 1'b1;
    snk_gaps_on = 1'b1;

    // default 2x2 grid: extremes and a flat frame
    foreach (frame_a[i]) elev_queue.push_back(frame_a[i]);
    wait_idle();
    apb_write(d8fd_pkg::REG_GRID_ROWS, 32'd3);
    apb_write(d8fd_pkg::REG_GRID_COLS, 32'd3);
    @(negedge clk_i);
    // diagonal against orthogonal drops, then ties
    foreach (frame_b[i]) elev_queue.push_back(frame_b[i]);

    run_raster(32'd0, 32'd1, 4);
    run_raster(32'd65535, 32'd2, 8);
    run_raster(32'd2, 32'd4095, 12);
    run_raster(32'd4, 32'd7, 28);
    run_raster(32'hABCD_0004, 32'h1234_5003, 12);
    repeat (2) run_raster($urandom_range(2, 5), $urandom_range(2, 6), $urandom_range(4, 12));

    wait_idle();
    src_gaps_on = 1'b0;
    snk_gaps_on = 1'b0;
    run_raster(32'd3, 32'd4, 12);
    wait_idle();

    if (err_count == 0 && flow_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
